### sv/hav_pkg.sv
// ----------------------------------------------------------------------------
// hav_pkg
// Shared constants and elaboration-time table builders for the haversine
// distance pipeline (atan table, CORDIC gain, degree-to-radian scale).
// ----------------------------------------------------------------------------
package hav_pkg;

  localparam int CORDIC_STEPS_DEF    = 24;
  localparam int ANGLE_FRAC_BITS_DEF = 30;

  localparam int LAT_W  = 28;
  localparam int LON_W  = 29;
  localparam int DIST_W = 25;

  localparam logic signed [LAT_W-1:0] LAT_MAX = 28'sd90000000;
  localparam logic signed [LON_W-1:0] LON_MAX = 29'sd180000000;
  localparam logic signed [LON_W:0]   LON_MAX_WIDE = 30'sd180000000;
  localparam logic signed [LON_W:0]   FULL_TURN    = 30'sd360000000;

  localparam logic signed [LAT_W-1:0] TARGET_LAT_RST = 28'sd41391819;
  localparam logic signed [LON_W-1:0] TARGET_LON_RST = 29'sd2177176;

  localparam logic [23:0]       TWO_R_M     = 24'd12742000;
  localparam logic [DIST_W-1:0] HALF_CIRC_M = 25'd20015087;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LAT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LON = 1'b1;

  localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;

  // Microdegrees to radians, Q62 scaled by 1/1440000000, rounded
  localparam int RAD_SCALE_W = 34;
  localparam logic [63:0] RAD_SCALE_Q = (PI_Q62 + 64'd720000000) / 64'd1440000000;
  localparam logic [RAD_SCALE_W-1:0] RAD_SCALE = RAD_SCALE_Q[RAD_SCALE_W-1:0];

  // Shift-subtract division, used only while building tables
  function automatic logic [63:0] udiv(logic [63:0] n, logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Rounded product a*b / 2^s
  function automatic logic [63:0] mulr(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p + (128'd1 << (s - 1));
    p = p >> s;
    return p[63:0];
  endfunction

  function automatic logic [63:0] q62_to_f(logic [63:0] a, int f);
    return (a + (64'd1 << (61 - f))) >> (62 - f);
  endfunction

  function automatic logic [63:0] atan_q62(int i);
    logic [63:0] sum;
    logic [63:0] t;
    int e;
    sum = '0;
    for (int k = 0; k < 32; k++) begin
      e = i * (2 * k + 1);
      if (e <= 62) begin
        t = udiv(64'd1 << (62 - e), 64'(2 * k + 1));
        if (k[0]) sum = sum - t;
        else      sum = sum + t;
      end
    end
    return sum;
  endfunction

  function automatic logic [63:0] atan_f(int i, int f);
    if (i == 0) return q62_to_f(PI_Q62 >> 2, f);
    return q62_to_f(atan_q62(i), f);
  endfunction

  // 1/sqrt(prod(1 + 2^-2i)) by Newton steps
  function automatic logic [63:0] gain_inv_f(int n, int f);
    logic [63:0] p;
    logic [63:0] y;
    logic [63:0] t;
    logic [63:0] u;
    logic [63:0] v;
    logic [63:0] three;
    p     = 64'd1 << 62;
    y     = (64'd1 << 61) + (64'd1 << 59);
    three = 64'd3 << 62;
    for (int i = 0; i < n; i++) p = p + (p >> (2 * i));
    for (int j = 0; j < 8; j++) begin
      t = mulr(y, y, 62);
      u = mulr(p, t, 62);
      v = (u < three) ? three - u : 64'd0;
      y = mulr(y, v, 63);
    end
    return q62_to_f(y, f);
  endfunction

endpackage

### sv/hav_front.sv
// ----------------------------------------------------------------------------
// hav_front
// Clamp positions, form half-angle deltas and doubled latitudes, scale
// microdegrees to Q2.F radians. Four register stages.
// ----------------------------------------------------------------------------
module hav_front #(
  parameter int ANGLE_FRAC_BITS = hav_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             valid_i,
  input  logic signed [hav_pkg::LAT_W-1:0] cur_lat_i,
  input  logic signed [hav_pkg::LON_W-1:0] cur_lon_i,
  input  logic signed [hav_pkg::LAT_W-1:0] tgt_lat_i,
  input  logic signed [hav_pkg::LON_W-1:0] tgt_lon_i,
  output logic                             valid_o,
  output logic signed [ANGLE_FRAC_BITS+2:0] z_dlat_o,
  output logic signed [ANGLE_FRAC_BITS+2:0] z_dlon_o,
  output logic signed [ANGLE_FRAC_BITS+2:0] z_lat1_o,
  output logic signed [ANGLE_FRAC_BITS+2:0] z_lat2_o
);

  localparam int F  = ANGLE_FRAC_BITS;
  localparam int AW = F + 3;
  localparam int MW = 28;
  localparam int PW = MW + hav_pkg::RAD_SCALE_W;
  localparam int SH = 60 - F;
  localparam int LW = hav_pkg::LAT_W;
  localparam int OW = hav_pkg::LON_W;

  // Stage A: clamp and differences
  logic signed [LW-1:0] lat1, lat2;
  logic signed [OW-1:0] lon1, lon2;
  logic signed [OW-1:0] dlat_a_r, lat1x2_a_r, lat2x2_a_r;
  logic signed [OW:0]   dlon_a_r;
  logic                 valid_a_r;

  always_comb begin
    lat1 = (cur_lat_i > hav_pkg::LAT_MAX) ? hav_pkg::LAT_MAX :
           (cur_lat_i < -hav_pkg::LAT_MAX) ? -hav_pkg::LAT_MAX : cur_lat_i;
    lat2 = (tgt_lat_i > hav_pkg::LAT_MAX) ? hav_pkg::LAT_MAX :
           (tgt_lat_i < -hav_pkg::LAT_MAX) ? -hav_pkg::LAT_MAX : tgt_lat_i;
    lon1 = (cur_lon_i > hav_pkg::LON_MAX) ? hav_pkg::LON_MAX :
           (cur_lon_i < -hav_pkg::LON_MAX) ? -hav_pkg::LON_MAX : cur_lon_i;
    lon2 = (tgt_lon_i > hav_pkg::LON_MAX) ? hav_pkg::LON_MAX :
           (tgt_lon_i < -hav_pkg::LON_MAX) ? -hav_pkg::LON_MAX : tgt_lon_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
    end else if (en) begin
      valid_a_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dlat_a_r   <= {lat2[LW-1], lat2} - {lat1[LW-1], lat1};
      dlon_a_r   <= {lon2[OW-1], lon2} - {lon1[OW-1], lon1};
      lat1x2_a_r <= {lat1, 1'b0};
      lat2x2_a_r <= {lat2, 1'b0};
    end
  end

  // Stage B: wrap longitude, split into magnitude and sign
  logic signed [OW:0]   dlon_w;
  logic signed [OW-1:0] vals [4];
  logic [MW-1:0]        mag_b_r [4];
  logic [3:0]           neg_b_r;
  logic                 valid_b_r;

  always_comb begin
    dlon_w = dlon_a_r;
    if (dlon_a_r > hav_pkg::LON_MAX_WIDE)       dlon_w = dlon_a_r - hav_pkg::FULL_TURN;
    else if (dlon_a_r < -hav_pkg::LON_MAX_WIDE) dlon_w = dlon_a_r + hav_pkg::FULL_TURN;
    vals[0] = dlat_a_r;
    vals[1] = dlon_w[OW-1:0];
    vals[2] = lat1x2_a_r;
    vals[3] = lat2x2_a_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_b_r <= 1'b0;
    end else if (en) begin
      valid_b_r <= valid_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        neg_b_r[k] <= vals[k][OW-1];
        mag_b_r[k] <= vals[k][OW-1] ? MW'(-vals[k]) : vals[k][MW-1:0];
      end
    end
  end

  // Stage C: scale by pi/1440000000 in Q62
  logic [PW-1:0] prod_c_r [4];
  logic [3:0]    neg_c_r;
  logic          valid_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_c_r <= 1'b0;
    end else if (en) begin
      valid_c_r <= valid_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_c_r <= neg_b_r;
      for (int k = 0; k < 4; k++) begin
        prod_c_r[k] <= PW'(mag_b_r[k]) * PW'(hav_pkg::RAD_SCALE);
      end
    end
  end

  // Stage D: round to nearest Q2.F and restore sign
  logic [PW:0]          rsum [4];
  logic signed [AW-1:0] rmag [4];
  logic signed [AW-1:0] z_d_r [4];
  logic                 valid_d_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rsum[k] = ({1'b0, prod_c_r[k]} + ((PW+1)'(1) << (SH - 1))) >> SH;
      rmag[k] = AW'(rsum[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_d_r <= 1'b0;
    end else if (en) begin
      valid_d_r <= valid_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        z_d_r[k] <= neg_c_r[k] ? -rmag[k] : rmag[k];
      end
    end
  end

  assign valid_o  = valid_d_r;
  assign z_dlat_o = z_d_r[0];
  assign z_dlon_o = z_d_r[1];
  assign z_lat1_o = z_d_r[2];
  assign z_lat2_o = z_d_r[3];

endmodule

### sv/hav_rot.sv
// ----------------------------------------------------------------------------
// hav_rot
// Rotation-mode CORDIC, one register stage per step. Gives cos and sin of z.
// ----------------------------------------------------------------------------
module hav_rot #(
  parameter int CORDIC_STEPS    = hav_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = hav_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              valid_i,
  input  logic signed [ANGLE_FRAC_BITS+2:0] z_i,
  output logic                              valid_o,
  output logic signed [ANGLE_FRAC_BITS+2:0] x_o,
  output logic signed [ANGLE_FRAC_BITS+2:0] y_o
);

  localparam int N  = CORDIC_STEPS;
  localparam int F  = ANGLE_FRAC_BITS;
  localparam int AW = F + 3;
  localparam logic signed [AW-1:0] Gain = AW'(hav_pkg::gain_inv_f(N, F));

  logic signed [AW-1:0] x_r [N];
  logic signed [AW-1:0] y_r [N];
  logic signed [AW-1:0] z_r [N];
  logic [N-1:0]         v_r;

  for (genvar i = 0; i < N; i++) begin : g_step
    localparam logic signed [AW-1:0] Atan = AW'(hav_pkg::atan_f(i, F));
    logic signed [AW-1:0] xp, yp, zp;
    logic                 vp;

    if (i == 0) begin : g_first
      assign xp = Gain;
      assign yp = '0;
      assign zp = z_i;
      assign vp = valid_i;
    end else begin : g_next
      assign xp = x_r[i-1];
      assign yp = y_r[i-1];
      assign zp = z_r[i-1];
      assign vp = v_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= vp;
      end
    end

    // rotate toward zero residual angle
    always_ff @(posedge clk) begin
      if (en) begin
        if (zp >= 0) begin
          x_r[i] <= xp - (yp >>> i);
          y_r[i] <= yp + (xp >>> i);
          z_r[i] <= zp - Atan;
        end else begin
          x_r[i] <= xp + (yp >>> i);
          y_r[i] <= yp - (xp >>> i);
          z_r[i] <= zp + Atan;
        end
      end
    end
  end

  assign valid_o = v_r[N-1];
  assign x_o     = x_r[N-1];
  assign y_o     = y_r[N-1];

endmodule

### sv/hav_core.sv
// ----------------------------------------------------------------------------
// hav_core
// Haversine term h = s1^2 + cos1*cos2*s2^2 and its complement 1 - h.
// Five register stages, at most one multiply level per stage.
// ----------------------------------------------------------------------------
module hav_core #(
  parameter int ANGLE_FRAC_BITS = hav_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                valid_i,
  input  logic signed [ANGLE_FRAC_BITS+2:0]   c1_i,
  input  logic signed [ANGLE_FRAC_BITS+2:0]   c2_i,
  input  logic signed [ANGLE_FRAC_BITS+2:0]   s1_i,
  input  logic signed [ANGLE_FRAC_BITS+2:0]   s2_i,
  output logic                                valid_o,
  output logic [2*ANGLE_FRAC_BITS:0]          h_o,
  output logic [2*ANGLE_FRAC_BITS:0]          g_o
);

  localparam int F  = ANGLE_FRAC_BITS;
  localparam int CW = F + 2;
  localparam int PW = 2 * CW;
  localparam int HW = 2 * F + 1;
  localparam logic [PW:0] One2 = (PW+1)'(1) << (2 * F);

  logic [4:0] v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], valid_i};
    end
  end

  // K1: drop negative cosines, take |sin|
  logic [CW-1:0] c1_k1_r, c2_k1_r, a1_k1_r, a2_k1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c1_k1_r <= (c1_i < 0) ? '0 : c1_i[CW-1:0];
      c2_k1_r <= (c2_i < 0) ? '0 : c2_i[CW-1:0];
      a1_k1_r <= (s1_i < 0) ? CW'(-s1_i) : s1_i[CW-1:0];
      a2_k1_r <= (s2_i < 0) ? CW'(-s2_i) : s2_i[CW-1:0];
    end
  end

  // K2: c1*c2 rounded, s1^2
  logic [PW-1:0] pc;
  logic [PW-1:0] pc_rnd;
  logic [CW-1:0] c12_k2_r, a2_k2_r;
  logic [PW-1:0] a1sq_k2_r;

  assign pc     = PW'(c1_k1_r) * PW'(c2_k1_r);
  assign pc_rnd = (pc + (PW'(1) << (F - 1))) >> F;

  always_ff @(posedge clk) begin
    if (en) begin
      c12_k2_r  <= pc_rnd[CW-1:0];
      a1sq_k2_r <= PW'(a1_k1_r) * PW'(a1_k1_r);
      a2_k2_r   <= a2_k1_r;
    end
  end

  // K3: c12*|s2| rounded
  logic [PW-1:0] pm;
  logic [PW-1:0] pm_rnd;
  logic [CW-1:0] m_k3_r, a2_k3_r;
  logic [PW-1:0] a1sq_k3_r;

  assign pm     = PW'(c12_k2_r) * PW'(a2_k2_r);
  assign pm_rnd = (pm + (PW'(1) << (F - 1))) >> F;

  always_ff @(posedge clk) begin
    if (en) begin
      m_k3_r    <= pm_rnd[CW-1:0];
      a2_k3_r   <= a2_k2_r;
      a1sq_k3_r <= a1sq_k2_r;
    end
  end

  // K4: m*|s2|
  logic [PW-1:0] ma_k4_r, a1sq_k4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ma_k4_r   <= PW'(m_k3_r) * PW'(a2_k3_r);
      a1sq_k4_r <= a1sq_k3_r;
    end
  end

  // K5: sum, clamp to one, complement
  logic [PW:0]   hs;
  logic [PW:0]   hc;
  logic [HW-1:0] h_k5_r, g_k5_r;

  always_comb begin
    hs = {1'b0, a1sq_k4_r} + {1'b0, ma_k4_r};
    hc = (hs > One2) ? One2 : hs;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_k5_r <= hc[HW-1:0];
      g_k5_r <= HW'(One2 - hc);
    end
  end

  assign valid_o = v_r[4];
  assign h_o     = h_k5_r;
  assign g_o     = g_k5_r;

endmodule

### sv/hav_sqrt.sv
// ----------------------------------------------------------------------------
// hav_sqrt
// Pipelined floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module hav_sqrt #(
  parameter int ANGLE_FRAC_BITS = hav_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        valid_i,
  input  logic [2*ANGLE_FRAC_BITS:0]  n_i,
  output logic                        valid_o,
  output logic [ANGLE_FRAC_BITS:0]    r_o
);

  localparam int F  = ANGLE_FRAC_BITS;
  localparam int HW = 2 * F + 1;
  localparam int RW = F + 1;
  localparam int TW = HW + 2;
  localparam int NS = F + 1;

  logic [HW-1:0] rem_r  [NS];
  logic [RW-1:0] root_r [NS];
  logic [NS-1:0] v_r;

  for (genvar j = 0; j < NS; j++) begin : g_bit
    localparam int B = F - j;
    logic [HW-1:0] remp;
    logic [RW-1:0] rootp;
    logic          vp;
    logic [TW-1:0] trial;

    if (j == 0) begin : g_first
      assign remp  = n_i;
      assign rootp = '0;
      assign vp    = valid_i;
    end else begin : g_next
      assign remp  = rem_r[j-1];
      assign rootp = root_r[j-1];
      assign vp    = v_r[j-1];
    end

    // (root + 2^B)^2 - root^2 = root*2^(B+1) + 2^(2B)
    assign trial = (TW'(rootp) << (B + 1)) | (TW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= vp;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (TW'(remp) >= trial) begin
          rem_r[j]  <= HW'(TW'(remp) - trial);
          root_r[j] <= rootp | (RW'(1) << B);
        end else begin
          rem_r[j]  <= remp;
          root_r[j] <= rootp;
        end
      end
    end
  end

  assign valid_o = v_r[NS-1];
  assign r_o     = root_r[NS-1];

endmodule

### sv/hav_vec.sv
// ----------------------------------------------------------------------------
// hav_vec
// Vectoring-mode CORDIC for atan2(u, v), then scale by earth diameter,
// round and saturate to metres.
// ----------------------------------------------------------------------------
module hav_vec #(
  parameter int CORDIC_STEPS    = hav_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = hav_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              valid_i,
  input  logic [ANGLE_FRAC_BITS:0]          u_i,
  input  logic [ANGLE_FRAC_BITS:0]          v_i,
  output logic                              valid_o,
  output logic [hav_pkg::DIST_W-1:0]        dist_o
);

  localparam int N  = CORDIC_STEPS;
  localparam int F  = ANGLE_FRAC_BITS;
  localparam int AW = F + 3;
  localparam int ZW = F + 1;
  localparam int PW = ZW + 24;
  localparam int DW = hav_pkg::DIST_W;

  logic signed [AW-1:0] x_r [N];
  logic signed [AW-1:0] y_r [N];
  logic signed [AW-1:0] z_r [N];
  logic [N-1:0]         v_r;

  for (genvar i = 0; i < N; i++) begin : g_step
    localparam logic signed [AW-1:0] Atan = AW'(hav_pkg::atan_f(i, F));
    logic signed [AW-1:0] xp, yp, zp;
    logic                 vp;

    if (i == 0) begin : g_first
      assign xp = {2'b00, v_i};
      assign yp = {2'b00, u_i};
      assign zp = '0;
      assign vp = valid_i;
    end else begin : g_next
      assign xp = x_r[i-1];
      assign yp = y_r[i-1];
      assign zp = z_r[i-1];
      assign vp = v_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= vp;
      end
    end

    // drive y toward zero, accumulate the angle
    always_ff @(posedge clk) begin
      if (en) begin
        if (yp >= 0) begin
          x_r[i] <= xp + (yp >>> i);
          y_r[i] <= yp - (xp >>> i);
          z_r[i] <= zp + Atan;
        end else begin
          x_r[i] <= xp - (yp >>> i);
          y_r[i] <= yp + (xp >>> i);
          z_r[i] <= zp - Atan;
        end
      end
    end
  end

  // Scale: clamp negative angle, multiply by 2R
  logic [ZW-1:0] zc;
  logic [PW-1:0] p_s1_r;
  logic [1:0]    vs_r;

  assign zc = (z_r[N-1] < 0) ? '0 : z_r[N-1][ZW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r <= '0;
    end else if (en) begin
      vs_r <= {vs_r[0], v_r[N-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_s1_r <= PW'(zc) * PW'(hav_pkg::TWO_R_M);
    end
  end

  // Round, saturate at half circumference
  logic [PW:0]   dw;
  logic [DW-1:0] d_s2_r;

  assign dw = ({1'b0, p_s1_r} + ((PW+1)'(1) << (F - 1))) >> F;

  always_ff @(posedge clk) begin
    if (en) begin
      d_s2_r <= (dw > (PW+1)'(hav_pkg::HALF_CIRC_M)) ? hav_pkg::HALF_CIRC_M : dw[DW-1:0];
    end
  end

  assign valid_o = vs_r[1];
  assign dist_o  = d_s2_r;

endmodule

### sv/haversine_distance.sv
// ----------------------------------------------------------------------------
// haversine_distance
// Great-circle distance in metres from a stream of positions to a target.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle; the pipeline advances as a whole whenever the
//   two-word output buffer has room.
// Reset: synchronous active-low rst_n clears every valid bit and the output
//   buffer, and loads the default target position.
// ----------------------------------------------------------------------------
module haversine_distance #(
  parameter int CORDIC_STEPS    = hav_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = hav_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input word
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [hav_pkg::LAT_W-1:0]    in_cur_lat_udeg,
  input  logic signed [hav_pkg::LON_W-1:0]    in_cur_lon_udeg,
  // result word
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [hav_pkg::DIST_W-1:0]          out_distance_m,
  // target position registers
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hav_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hav_pkg::LON_W-1:0]           cfg_data
);

  localparam int F  = ANGLE_FRAC_BITS;
  localparam int AW = F + 3;
  localparam int HW = 2 * F + 1;
  localparam int DW = hav_pkg::DIST_W;

  // --------------------------------------------------------------------------
  // Target registers. The user must write them only while the pipeline is
  // drained; the block does not enforce this. The front end reads them directly.
  // --------------------------------------------------------------------------
  logic signed [hav_pkg::LAT_W-1:0] tgt_lat_r;
  logic signed [hav_pkg::LON_W-1:0] tgt_lon_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_lat_r <= hav_pkg::TARGET_LAT_RST;
      tgt_lon_r <= hav_pkg::TARGET_LON_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hav_pkg::CFG_TARGET_LAT: tgt_lat_r <= cfg_data[hav_pkg::LAT_W-1:0];
        hav_pkg::CFG_TARGET_LON: tgt_lon_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Global advance. The enable comes from the output buffer fill only, so it
  // never waits on out_stall combinationally; a word pushed while one sits in
  // the buffer still fits in the second slot.
  // --------------------------------------------------------------------------
  logic [1:0] count_r, count_nxt;
  logic       en;

  assign en       = (count_r != 2'd2);
  assign in_stall = !en;

  // Front end: clamp, deltas, radians
  logic                 fr_valid;
  logic signed [AW-1:0] z_dlat, z_dlon, z_lat1, z_lat2;

  hav_front #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .valid_i   (in_valid),
    .cur_lat_i (in_cur_lat_udeg),
    .cur_lon_i (in_cur_lon_udeg),
    .tgt_lat_i (tgt_lat_r),
    .tgt_lon_i (tgt_lon_r),
    .valid_o   (fr_valid),
    .z_dlat_o  (z_dlat),
    .z_dlon_o  (z_dlon),
    .z_lat1_o  (z_lat1),
    .z_lat2_o  (z_lat2)
  );

  // Four rotation lanes in lockstep: sines of the half deltas, cosines of
  // the two latitudes. Lane 0 carries the valid bit for all of them.
  logic                 rot_valid;
  logic signed [AW-1:0] s1, s2, c1, c2;

  hav_rot #(
    .CORDIC_STEPS    (CORDIC_STEPS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_rot_dlat (
    .clk (clk), .rst_n (rst_n), .en (en),
    .valid_i (fr_valid), .z_i (z_dlat),
    .valid_o (rot_valid), .x_o (), .y_o (s1)
  );

  hav_rot #(
    .CORDIC_STEPS    (CORDIC_STEPS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_rot_dlon (
    .clk (clk), .rst_n (rst_n), .en (en),
    .valid_i (fr_valid), .z_i (z_dlon),
    .valid_o (), .x_o (), .y_o (s2)
  );

  hav_rot #(
    .CORDIC_STEPS    (CORDIC_STEPS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_rot_lat1 (
    .clk (clk), .rst_n (rst_n), .en (en),
    .valid_i (fr_valid), .z_i (z_lat1),
    .valid_o (), .x_o (c1), .y_o ()
  );

  hav_rot #(
    .CORDIC_STEPS    (CORDIC_STEPS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_rot_lat2 (
    .clk (clk), .rst_n (rst_n), .en (en),
    .valid_i (fr_valid), .z_i (z_lat2),
    .valid_o (), .x_o (c2), .y_o ()
  );

  // Haversine term and complement
  logic          core_valid;
  logic [HW-1:0] h, g;

  hav_core #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (rot_valid),
    .c1_i    (c1),
    .c2_i    (c2),
    .s1_i    (s1),
    .s2_i    (s2),
    .valid_o (core_valid),
    .h_o     (h),
    .g_o     (g)
  );

  // sqrt(h) and sqrt(1 - h) side by side
  logic         sq_valid;
  logic [F:0]   u_root, v_root;

  hav_sqrt #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_sqrt_h (
    .clk (clk), .rst_n (rst_n), .en (en),
    .valid_i (core_valid), .n_i (h),
    .valid_o (sq_valid), .r_o (u_root)
  );

  hav_sqrt #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_sqrt_g (
    .clk (clk), .rst_n (rst_n), .en (en),
    .valid_i (core_valid), .n_i (g),
    .valid_o (), .r_o (v_root)
  );

  // Half central angle, then metres
  logic          vec_valid;
  logic [DW-1:0] vec_dist;

  hav_vec #(
    .CORDIC_STEPS    (CORDIC_STEPS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_vec (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (sq_valid),
    .u_i     (u_root),
    .v_i     (v_root),
    .valid_o (vec_valid),
    .dist_o  (vec_dist)
  );

  // --------------------------------------------------------------------------
  // Two-word output buffer. Slot 0 is the head shown on the port.
  // --------------------------------------------------------------------------
  logic [DW-1:0] slot0_r, slot1_r, slot0_nxt, slot1_nxt;
  logic          push, pop;

  assign push = en && vec_valid;
  assign pop  = out_valid && !out_stall;

  always_comb begin
    count_nxt = count_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    case ({push, pop})
      2'b10: begin
        // append behind whatever is held
        if (count_r == 2'd0) slot0_nxt = vec_dist;
        else                 slot1_nxt = vec_dist;
        count_nxt = count_r + 2'd1;
      end
      2'b01: begin
        // advance the second slot to the head
        slot0_nxt = slot1_r;
        count_nxt = count_r - 2'd1;
      end
      2'b11: begin
        // push only happens below full, so exactly one word was held
        slot0_nxt = vec_dist;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  assign out_valid      = (count_r != 2'd0);
  assign out_distance_m = slot0_r;

endmodule

### sv/hav_checker.sv
// ----------------------------------------------------------------------------
// hav_checker
// Port-level checks on the distance block, bound to the top level.
// ----------------------------------------------------------------------------
module hav_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [hav_pkg::DIST_W-1:0] out_distance_m
);

  // held result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_distance_m))
    else $error("result word changed while stalled");

  // saturation at half circumference
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_distance_m <= hav_pkg::HALF_CIRC_M)
    else $error("distance above half circumference");

  // reset drains the output buffer and opens the input
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output not empty after reset");

endmodule

bind haversine_distance hav_checker u_hav_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_distance_m (out_distance_m)
);
